// ----- rtl/core/rc5_pkg.sv -----
// Shared types, constants and rotate helpers for the RC5-32/12/16 cipher.
// No dependencies; imported by every module of the block but rc5_checker.
package rc5_pkg;

  localparam int ROUNDS      = 12;
  localparam int TABLE_SIZE  = 2 * ROUNDS + 2;
  localparam int KEY_WORDS   = 4;
  localparam int MIX_STEPS   = 3 * ((TABLE_SIZE > KEY_WORDS) ? TABLE_SIZE : KEY_WORDS);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int KW_W   = $clog2(KEY_WORDS);
  localparam int STEP_W = $clog2(MIX_STEPS);

  localparam int WORD_W    = 32;
  localparam int KEY_REG_W = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] MAGIC_P = 32'hb7e15163;
  localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9e3779b9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(1);

  // Operations of the shared round unit
  typedef enum logic [2:0] {
    OP_ADD,    // x + k
    OP_SUB,    // x - k
    OP_ENC,    // rotl(x ^ y, y) + k
    OP_DEC,    // rotr(x - k, y) ^ y
    OP_MIX_A,  // rotl(k + x + y, 3)
    OP_MIX_B   // rotl(k + x + y, x + y)
  } rc5_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MIX_PRIME,
    ST_MIX_A,
    ST_MIX_B,
    ST_CIPH_PRIME,
    ST_CIPH
  } rc5_state_t;

  // Round-key table access, one write and one read address per cycle
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } rc5_ram_req_t;

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                               input logic [4:0] n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} << n;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                               input logic [4:0] n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} >> n;
    return d[WORD_W-1:0];
  endfunction

endpackage

// ----- rtl/core/rc5_key_ram.sv -----
// Round-key table: one write port and one registered read port.
// Depends on rc5_pkg for the table depth and the access struct.
module rc5_key_ram
  import rc5_pkg::*;
(
  input  logic              clk,
  input  rc5_ram_req_t      req,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [TABLE_SIZE];
  logic [WORD_W-1:0] rdata_r;

  // Write one word
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/rc5_round_unit.sv -----
// Shared arithmetic unit: add, subtract, xor and data-dependent rotate.
// Serves both key mixing and the cipher half-rounds; depends on rc5_pkg.
module rc5_round_unit
  import rc5_pkg::*;
(
  input  rc5_op_t           op,
  input  logic [WORD_W-1:0] x,
  input  logic [WORD_W-1:0] y,
  input  logic [WORD_W-1:0] k,
  output logic [WORD_W-1:0] res
);

  logic [WORD_W-1:0] xy_sum;
  logic [WORD_W-1:0] mix_sum;

  assign xy_sum  = x + y;
  assign mix_sum = k + xy_sum;

  // Select the operation
  always_comb begin
    unique case (op)
      OP_ADD:   res = x + k;
      OP_SUB:   res = x - k;
      OP_ENC:   res = rotl32(x ^ y, y[4:0]) + k;
      OP_DEC:   res = rotr32(x - k, y[4:0]) ^ y;
      OP_MIX_A: res = rotl32(mix_sum, 5'd3);
      OP_MIX_B: res = rotl32(mix_sum, xy_sum[4:0]);
      default:  res = '0;
    endcase
  end

endmodule

// ----- rtl/core/rc5_engine.sv -----
// Sequencer and working registers for key expansion and block processing.
// Instantiates rc5_key_ram and rc5_round_unit; depends on rc5_pkg.
module rc5_engine
  import rc5_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 action,
  input  logic [WORD_W-1:0]    block_a,
  input  logic [WORD_W-1:0]    block_b,
  input  logic [KEY_REG_W-1:0] key_low,
  input  logic [KEY_REG_W-1:0] key_high,
  input  logic                 sched_valid,
  output logic                 busy,
  output logic                 sched_done,
  output logic                 res_valid,
  output logic [WORD_W-1:0]    res_a,
  output logic [WORD_W-1:0]    res_b
);

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_SIZE - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MIX_STEPS - 1);

  rc5_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [KW_W-1:0]    j_r, j_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [WORD_W-1:0]  fill_r, fill_nxt;
  logic [WORD_W-1:0]  mix_a_r, mix_a_nxt;
  logic [WORD_W-1:0]  mix_b_r, mix_b_nxt;
  logic [WORD_W-1:0]  blk_a_r, blk_a_nxt;
  logic [WORD_W-1:0]  blk_b_r, blk_b_nxt;
  logic               dec_r, dec_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  l_r [KEY_WORDS];
  logic               l_load, l_we;

  rc5_ram_req_t       ram_req;
  logic [WORD_W-1:0]  ram_rdata;
  rc5_op_t            op;
  logic [WORD_W-1:0]  op_x, op_y, op_k, op_res;
  logic [IDX_W-1:0]   idx_wrap;
  logic [IDX_W-1:0]   idx_ciph_nxt;
  logic [IDX_W-1:0]   first_idx;
  logic               ciph_last;

  rc5_key_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  rc5_round_unit u_unit (
    .op  (op),
    .x   (op_x),
    .y   (op_y),
    .k   (op_k),
    .res (op_res)
  );

  // Table index helpers
  assign idx_wrap     = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
  assign idx_ciph_nxt = dec_r ? idx_r - 1'b1 : idx_r + 1'b1;
  assign ciph_last    = dec_r ? (idx_r == '0) : (idx_r == IDX_LAST);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    j_r     <= j_nxt;
    step_r  <= step_nxt;
    fill_r  <= fill_nxt;
    mix_a_r <= mix_a_nxt;
    mix_b_r <= mix_b_nxt;
    blk_a_r <= blk_a_nxt;
    blk_b_r <= blk_b_nxt;
    dec_r   <= dec_nxt;
  end

  // Key words: load from the key registers, update one per mix step
  always_ff @(posedge clk) begin
    if (l_load) begin
      l_r[0] <= key_low[WORD_W-1:0];
      l_r[1] <= key_low[KEY_REG_W-1:WORD_W];
      l_r[2] <= key_high[WORD_W-1:0];
      l_r[3] <= key_high[KEY_REG_W-1:WORD_W];
    end else if (l_we) begin
      l_r[j_r] <= op_res;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    step_nxt      = step_r;
    fill_nxt      = fill_r;
    mix_a_nxt     = mix_a_r;
    mix_b_nxt     = mix_b_r;
    blk_a_nxt     = blk_a_r;
    blk_b_nxt     = blk_b_r;
    dec_nxt       = dec_r;
    out_valid_nxt = 1'b0;
    l_load        = 1'b0;
    l_we          = 1'b0;
    sched_done    = 1'b0;
    ram_req       = '{we: 1'b0, waddr: idx_r, wdata: op_res, raddr: idx_r};
    op            = OP_ADD;
    op_x          = blk_a_r;
    op_y          = blk_b_r;
    op_k          = ram_rdata;
    first_idx     = dec_r ? IDX_LAST : '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          blk_a_nxt = block_a;
          blk_b_nxt = block_b;
          dec_nxt   = action;
          if (sched_valid) begin
            idx_nxt   = action ? IDX_LAST : '0;
            state_nxt = ST_CIPH_PRIME;
          end else begin
            idx_nxt   = '0;
            fill_nxt  = MAGIC_P;
            l_load    = 1'b1;
            state_nxt = ST_FILL;
          end
        end
      end

      // Seed the table with P + n*Q
      ST_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = fill_r;
        fill_nxt      = fill_r + MAGIC_Q;
        idx_nxt       = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          idx_nxt   = '0;
          j_nxt     = '0;
          step_nxt  = '0;
          mix_a_nxt = '0;
          mix_b_nxt = '0;
          state_nxt = ST_MIX_PRIME;
        end
      end

      // Fetch the first table word
      ST_MIX_PRIME: begin
        state_nxt = ST_MIX_A;
      end

      // Mix the table word and write it back
      ST_MIX_A: begin
        op         = OP_MIX_A;
        op_x       = mix_a_r;
        op_y       = mix_b_r;
        op_k       = ram_rdata;
        ram_req.we = 1'b1;
        mix_a_nxt  = op_res;
        state_nxt  = ST_MIX_B;
      end

      // Mix the key word and fetch the next table word
      ST_MIX_B: begin
        op            = OP_MIX_B;
        op_x          = mix_a_r;
        op_y          = mix_b_r;
        op_k          = l_r[j_r];
        l_we          = 1'b1;
        mix_b_nxt     = op_res;
        j_nxt         = j_r + 1'b1;
        step_nxt      = step_r + 1'b1;
        idx_nxt       = idx_wrap;
        ram_req.raddr = idx_wrap;
        state_nxt     = ST_MIX_A;
        if (step_r == STEP_LAST) begin
          sched_done = 1'b1;
          idx_nxt    = first_idx;
          state_nxt  = ST_CIPH_PRIME;
        end
      end

      // Fetch the first round key of the block
      ST_CIPH_PRIME: begin
        state_nxt = ST_CIPH;
      end

      // One half-round per beat: odd keys update word b, even keys word a
      ST_CIPH: begin
        op_k = ram_rdata;
        if (idx_r[0]) begin
          op_x = blk_b_r;
          op_y = blk_a_r;
        end else begin
          op_x = blk_a_r;
          op_y = blk_b_r;
        end
        if (idx_r < IDX_W'(2)) begin
          op = dec_r ? OP_SUB : OP_ADD;
        end else begin
          op = dec_r ? OP_DEC : OP_ENC;
        end
        if (idx_r[0]) begin
          blk_b_nxt = op_res;
        end else begin
          blk_a_nxt = op_res;
        end
        idx_nxt       = idx_ciph_nxt;
        ram_req.raddr = idx_ciph_nxt;
        if (ciph_last) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = out_valid_r;
  assign res_a     = blk_a_r;
  assign res_b     = blk_b_r;

endmodule

// ----- rtl/core/rc5_block_cipher_unit.sv -----
// Top level of the RC5-32/12/16 cipher: key registers, schedule flag, engine.
// Depends on rc5_pkg and rc5_engine.

// One block is accepted at a clock edge where start is high and busy is low;
// its result shows on out_result_a/out_result_b for exactly one cycle with
// out_valid high once the fetch and 26 half-rounds are done, and busy is
// already low in that cycle so the next block can be started there. The
// half-rounds (two per round, initial whitening included) pass through the
// single shared round unit, which reads one round key per cycle from the key
// table's single read port. The first block after reset or after any write
// to key_low or key_high first expands the key: it seeds the table, fetches
// the first table word and runs 78 mixing steps, each a MIX_A and a MIX_B
// state, before its half-rounds. out_valid cannot be stalled;
// the receiver must take each result in its cycle. Key writes are taken only
// while busy and start are both low.
module rc5_block_cipher_unit
  import rc5_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_action,
  input  logic [WORD_W-1:0]    in_block_a,
  input  logic [WORD_W-1:0]    in_block_b,
  output logic                 out_valid,
  output logic [WORD_W-1:0]    out_result_a,
  output logic [WORD_W-1:0]    out_result_b,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_REG_W-1:0] cfg_data
);

  logic [KEY_REG_W-1:0] key_low_r;
  logic [KEY_REG_W-1:0] key_high_r;
  logic                 sched_valid_r;
  logic                 cfg_fire;
  logic                 key_write;
  logic                 sched_done;

  // Take key writes only between blocks, never on the beat a block starts
  assign cfg_ready = !busy && !start;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign key_write = cfg_fire && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH);

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_fire) begin
      if (cfg_index == REG_KEY_LOW) begin
        key_low_r <= cfg_data;
      end
      if (cfg_index == REG_KEY_HIGH) begin
        key_high_r <= cfg_data;
      end
    end
  end

  // Drop the schedule on a key write, hold it once expanded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_valid_r <= 1'b0;
    end else if (key_write) begin
      sched_valid_r <= 1'b0;
    end else if (sched_done) begin
      sched_valid_r <= 1'b1;
    end
  end

  rc5_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .action      (in_action),
    .block_a     (in_block_a),
    .block_b     (in_block_b),
    .key_low     (key_low_r),
    .key_high    (key_high_r),
    .sched_valid (sched_valid_r),
    .busy        (busy),
    .sched_done  (sched_done),
    .res_valid   (out_valid),
    .res_a       (out_result_a),
    .res_b       (out_result_b)
  );

endmodule

// ----- rtl/core/rc5_checker.sv -----
// Port-level checks of the cipher's command handshake and result strobe,
// bound to rc5_block_cipher_unit; needs no package.
module rc5_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_valid,
  input logic cfg_ready
);

  // An accepted block keeps the block busy on the next beat
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted block did not raise busy");

  // Each result comes from a finished block
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe without a block in flight");

  // Finishing a block always delivers its result
  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // A result strobe lasts exactly one cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Key writes are never taken while a block is in flight
  a_cfg_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> !busy)
    else $error("key write accepted while busy");

endmodule

bind rc5_block_cipher_unit rc5_checker u_rc5_checker (.*);
